// File: rtl/hst_pkg.sv
// Shared types and constants for the hall speed, throttle and PWM block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package hst_pkg;

   localparam int unsigned SPEED_W    = 24;
   localparam int unsigned RATED_W    = 16;
   localparam int unsigned STALL_W    = 17;
   localparam int unsigned BAND_W     = 11;
   localparam int unsigned WRAP_W     = 16;
   localparam int unsigned TIMEOUT_W  = 20;
   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned THR_W      = 12;
   localparam int unsigned LEVEL_W    = 17;
   localparam int unsigned DUTY_W     = 17;
   localparam int unsigned ARG_W      = 20;
   localparam int unsigned DIV_DEN_W  = 28;
   localparam int unsigned DIV_BITS_W = 24;
   localparam int unsigned DIV_CNT_W  = 5;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 24;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [THR_W-1:0]  THR_FULL = 12'd4095;
   localparam logic [DUTY_W-1:0] DUTY_ONE = 17'd65536;

   localparam logic [CSR_IDX_W-1:0] REG_SPEED_CONSTANT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATED_SPEED    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STALL_OFFSET   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DEAD_BAND      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PERIOD_TOP     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STALL_TIMEOUT  = 3'd5;

   localparam logic [SPEED_W-1:0]   RST_SPEED_CONSTANT = 24'd2500000;
   localparam logic [RATED_W-1:0]   RST_RATED_SPEED    = 16'd3000;
   localparam logic [STALL_W-1:0]   RST_STALL_OFFSET   = 17'd13653;
   localparam logic [BAND_W-1:0]    RST_DEAD_BAND      = 11'd100;
   localparam logic [WRAP_W-1:0]    RST_PERIOD_TOP     = 16'd24999;
   localparam logic [TIMEOUT_W-1:0] RST_STALL_TIMEOUT  = 20'd100000;

   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_HALL     = 2'd1;
   localparam logic [1:0] OP_THROTTLE = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_SPEED,
      CMD_THROTTLE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [ARG_W-1:0] arg;
   } cmd_type;

   typedef struct packed {
      logic [SPEED_W-1:0]   speed_constant;
      logic [RATED_W-1:0]   rated_speed;
      logic [STALL_W-1:0]   stall_offset_q16;
      logic [BAND_W-1:0]    dead_band;
      logic [WRAP_W-1:0]    period_top;
      logic [TIMEOUT_W-1:0] stall_timeout_us;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_DEN_W-1:0]  rem_init;
      logic [DIV_BITS_W-1:0] bits;
      logic [DIV_DEN_W-1:0]  den;
      logic [DIV_CNT_W-1:0]  steps;
   } div_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPEED,
      ST_THR,
      ST_MUL_A,
      ST_SUM,
      ST_MUL_B,
      ST_CHECK,
      ST_DUTY,
      ST_SCALE,
      ST_OUT
   } back_state_type;

endpackage

`default_nettype wire

// File: rtl/hst_front.sv
// Front end: accepts input beats, keeps the microsecond count and turns each beat
// into a command for the back end. Depends on hst_pkg.
`default_nettype none

module hst_front import hst_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_op,
   input  wire logic [SAMPLE_W-1:0]   req_adc_sample,
   input  wire logic [TIMEOUT_W-1:0]  stall_timeout_us,
   input  wire logic                  queue_full,
   output logic                       push,
   output cmd_type                    push_cmd
);

   logic [TIMEOUT_W-1:0] elapsed_ff;
   logic [TIMEOUT_W-1:0] elapsed_in;
   logic [TIMEOUT_W-1:0] limit;
   logic [TIMEOUT_W-1:0] incremented;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      limit       = (stall_timeout_us == '0) ? TIMEOUT_W'(1) : stall_timeout_us;
      incremented = (elapsed_ff != '1) ? elapsed_ff + TIMEOUT_W'(1) : elapsed_ff;
      elapsed_in  = elapsed_ff;
      push_cmd.kind = CMD_NONE;
      push_cmd.arg  = '0;
      unique case (req_op)
         OP_TICK: begin
            if (incremented >= limit) begin
               push_cmd.kind = CMD_SPEED;
               push_cmd.arg  = limit;
               elapsed_in    = '0;
            end else begin
               elapsed_in = incremented;
            end
         end
         OP_HALL: begin
            push_cmd.kind = CMD_SPEED;
            push_cmd.arg  = (elapsed_ff == '0) ? TIMEOUT_W'(1) : elapsed_ff;
            elapsed_in    = '0;
         end
         OP_THROTTLE: begin
            push_cmd.kind = CMD_THROTTLE;
            push_cmd.arg  = ARG_W'(req_adc_sample);
         end
         OP_UNUSED: begin
            push_cmd.kind = CMD_NONE;
         end
         default: begin
            push_cmd.kind = CMD_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else if (push) begin
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/hst_queue.sv
// Short command queue between the front end and the back end.
// Depends on hst_pkg for the command type and depth.
`default_nettype none

module hst_queue import hst_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  cmd_type   push_cmd,
   output logic      full,
   input  wire logic pop,
   output logic      head_valid,
   output cmd_type   head_cmd
);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QPTR_W:0]    count_ff;
   logic               do_push;
   logic               do_pop;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// File: rtl/hst_div.sv
// Shared restoring divider, one quotient bit per cycle, used for speed, dead zone
// and duty. Depends on hst_pkg for the request type and widths.
`default_nettype none

module hst_div import hst_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  div_req_type            req,
   output logic                   done,
   output logic [DIV_BITS_W-1:0]  quotient
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [DIV_DEN_W-1:0]  rem_ff;
   logic [DIV_BITS_W-1:0] bits_ff;
   logic [DIV_DEN_W-1:0]  den_ff;
   logic [DIV_CNT_W-1:0]  cnt_ff;
   logic [DIV_BITS_W-1:0] quot_ff;
   logic [DIV_DEN_W:0]    trial;
   logic                  fits;

   assign trial    = {rem_ff, bits_ff[DIV_BITS_W-1]};
   assign fits     = (trial >= {1'b0, den_ff});
   assign done     = done_ff;
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= !req.start && busy_ff && (cnt_ff == DIV_CNT_W'(1));
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == DIV_CNT_W'(1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= req.rem_init;
         bits_ff <= req.bits;
         den_ff  <= req.den;
         cnt_ff  <= req.steps;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         bits_ff <= {bits_ff[DIV_BITS_W-2:0], 1'b0};
         cnt_ff  <= cnt_ff - DIV_CNT_W'(1);
         quot_ff <= {quot_ff[DIV_BITS_W-2:0], fits};
      end
   end

endmodule

`default_nettype wire

// File: rtl/hst_back.sv
// Back end: executes queued commands (speed update, dead zone, PWM level) and
// holds the result register. Depends on hst_pkg and hst_div.
`default_nettype none

module hst_back import hst_pkg::*; #(
   parameter int unsigned ADC_BITS = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  cfg_type                  cfg,
   input  wire logic                head_valid,
   input  cmd_type                  head_cmd,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [LEVEL_W-1:0]       rsp_pwm_level,
   output logic [SPEED_W-1:0]       rsp_speed_rpm
);

   localparam logic [16:0] ADC_FULL = 17'((1 << ADC_BITS) - 1);

   back_state_type        state_ff;
   back_state_type        state_in;
   logic [SPEED_W-1:0]    speed_ff;
   logic [THR_W-1:0]      throttle_ff;
   logic                  rsp_valid_ff;
   logic [LEVEL_W-1:0]    level_ff;
   logic [SPEED_W-1:0]    speed_out_ff;
   logic [32:0]           prod_ff;
   logic [40:0]           sum_ff;
   logic [52:0]           num_ff;
   logic [DUTY_W-1:0]     duty_ff;
   logic [32:0]           scale_ff;

   div_req_type           div_req;
   logic                  div_done;
   logic [DIV_BITS_W-1:0] div_quot;

   logic [SAMPLE_W-1:0]   sample;
   logic [SAMPLE_W-1:0]   band;
   logic [16:0]           span;
   logic                  span_ok;
   logic                  below;
   logic                  above;
   logic [SAMPLE_W-1:0]   diff;
   logic [23:0]           thr_num;
   logic                  thr_direct;
   logic [RATED_W-1:0]    rated_eff;
   logic [DIV_DEN_W-1:0]  den_pwm;
   logic                  duty_sat;
   logic                  rsp_load;

   hst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      sample     = head_cmd.arg[SAMPLE_W-1:0];
      band       = {1'b0, cfg.dead_band};
      span       = ADC_FULL - {6'b0, cfg.dead_band};
      span_ok    = (ADC_FULL > {6'b0, cfg.dead_band});
      below      = (sample < band);
      above      = ({5'b0, sample} > span);
      diff       = sample - band;
      thr_num    = {diff, 12'b0} - {12'b0, diff};
      thr_direct = below || !span_ok || above;
      rated_eff  = (cfg.rated_speed == '0) ? RATED_W'(1) : cfg.rated_speed;
      den_pwm    = {rated_eff, 12'b0} - {12'b0, rated_eff};
      duty_sat   = (num_ff[52:17] >= {8'b0, den_pwm});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               unique case (head_cmd.kind)
                  CMD_SPEED:    state_in = ST_SPEED;
                  CMD_THROTTLE: state_in = thr_direct ? ST_MUL_A : ST_THR;
                  default:      state_in = ST_MUL_A;
               endcase
            end
         end
         ST_SPEED: if (div_done) state_in = ST_MUL_A;
         ST_THR:   if (div_done) state_in = ST_MUL_A;
         ST_MUL_A: state_in = ST_SUM;
         ST_SUM:   state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_CHECK;
         ST_CHECK: state_in = duty_sat ? ST_SCALE : ST_DUTY;
         ST_DUTY:  if (div_done) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop           = (state_ff == ST_IDLE) && head_valid;
      rsp_load      = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);
      div_req       = '0;
      if (pop && (head_cmd.kind == CMD_SPEED)) begin
         div_req.start    = 1'b1;
         div_req.rem_init = '0;
         div_req.bits     = cfg.speed_constant;
         div_req.den      = DIV_DEN_W'(head_cmd.arg);
         div_req.steps    = DIV_CNT_W'(24);
      end else if (pop && (head_cmd.kind == CMD_THROTTLE) && !thr_direct) begin
         div_req.start    = 1'b1;
         div_req.rem_init = DIV_DEN_W'(thr_num[23:12]);
         div_req.bits     = {thr_num[11:0], 12'b0};
         div_req.den      = DIV_DEN_W'(span[15:0]);
         div_req.steps    = DIV_CNT_W'(12);
      end else if ((state_ff == ST_CHECK) && !duty_sat) begin
         div_req.start    = 1'b1;
         div_req.rem_init = num_ff[44:17];
         div_req.bits     = {num_ff[16:0], 7'b0};
         div_req.den      = den_pwm;
         div_req.steps    = DIV_CNT_W'(17);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         speed_ff     <= '0;
         throttle_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop && (head_cmd.kind == CMD_THROTTLE) && thr_direct) begin
            throttle_ff <= below ? '0 : THR_FULL;
         end
         if ((state_ff == ST_SPEED) && div_done) begin
            speed_ff <= div_quot;
         end
         if ((state_ff == ST_THR) && div_done) begin
            throttle_ff <= div_quot[THR_W-1:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL_A) begin
         prod_ff <= 33'(cfg.stall_offset_q16) * 33'(rated_eff);
      end
      if (state_ff == ST_SUM) begin
         sum_ff <= {1'b0, speed_ff, 16'b0} + {8'b0, prod_ff};
      end
      if (state_ff == ST_MUL_B) begin
         num_ff <= 53'(throttle_ff) * 53'(sum_ff);
      end
      if ((state_ff == ST_CHECK) && duty_sat) begin
         duty_ff <= DUTY_ONE;
      end
      if ((state_ff == ST_DUTY) && div_done) begin
         duty_ff <= (div_quot[DUTY_W-1:0] > DUTY_ONE) ? DUTY_ONE : div_quot[DUTY_W-1:0];
      end
      if (state_ff == ST_SCALE) begin
         scale_ff <= 33'(duty_ff) * 33'(cfg.period_top);
      end
      if (rsp_load) begin
         level_ff     <= scale_ff[32:16] + LEVEL_W'(1);
         speed_out_ff <= speed_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pwm_level = level_ff;
   assign rsp_speed_rpm = speed_out_ff;

endmodule

`default_nettype wire

// File: rtl/hall_speed_throttle_pwm_top.sv
// Top level of the hall speed meter and throttle-to-PWM controller.
// Depends on hst_pkg, hst_front, hst_queue and hst_back (with hst_div).
//
// Usage: each input beat on req_ carries an op (microsecond tick, hall edge,
// throttle sample, or an unused code) and a 12-bit converter sample. Every
// accepted beat produces exactly one result beat on rsp_ with the PWM compare
// level and the current speed in rpm, in input order.
// The front end classifies a beat in the cycle it is accepted and queues a
// command; up to four commands may wait. The back end runs them one at a time,
// and its shared one-bit-per-cycle divider sets the time. A beat that only
// reports runs one division of 17 steps for the duty; a throttle sample
// (unless the dead band clamps it) and a speed update first run a division
// of 12 or 24 steps. A saturated duty skips its division.
// Configuration writes on csr_ are accepted every cycle and should be made
// while no beat is in flight. Reset clears the speed, throttle and elapsed
// count and loads the default register values.
// When the receiver stalls, the result register holds its beat; the back end
// finishes the next result and waits, and the queue keeps accepting beats
// until it fills, at which point req_ready drops.
`default_nettype none

module hall_speed_throttle_pwm_top import hst_pkg::*; #(
   parameter int unsigned ADC_BITS = 12
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_op,
   input  wire logic [SAMPLE_W-1:0]   req_adc_sample,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [LEVEL_W-1:0]         rsp_pwm_level,
   output logic [SPEED_W-1:0]         rsp_speed_rpm,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_constant   <= RST_SPEED_CONSTANT;
         cfg_ff.rated_speed      <= RST_RATED_SPEED;
         cfg_ff.stall_offset_q16 <= RST_STALL_OFFSET;
         cfg_ff.dead_band        <= RST_DEAD_BAND;
         cfg_ff.period_top       <= RST_PERIOD_TOP;
         cfg_ff.stall_timeout_us <= RST_STALL_TIMEOUT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SPEED_CONSTANT: cfg_ff.speed_constant   <= csr_wdata[SPEED_W-1:0];
            REG_RATED_SPEED:    cfg_ff.rated_speed      <= csr_wdata[RATED_W-1:0];
            REG_STALL_OFFSET:   cfg_ff.stall_offset_q16 <= csr_wdata[STALL_W-1:0];
            REG_DEAD_BAND:      cfg_ff.dead_band        <= csr_wdata[BAND_W-1:0];
            REG_PERIOD_TOP:     cfg_ff.period_top       <= csr_wdata[WRAP_W-1:0];
            REG_STALL_TIMEOUT:  cfg_ff.stall_timeout_us <= csr_wdata[TIMEOUT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hst_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_adc_sample   (req_adc_sample),
      .stall_timeout_us (cfg_ff.stall_timeout_us),
      .queue_full       (queue_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   hst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   hst_back #(
      .ADC_BITS (ADC_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_valid    (head_valid),
      .head_cmd      (head_cmd),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pwm_level (rsp_pwm_level),
      .rsp_speed_rpm (rsp_speed_rpm)
   );

endmodule

`default_nettype wire
